>>> src/beca_pkg.sv
// shared constants, codes and types of the block edge count accumulator
// no dependencies; imported by the top level

package beca_pkg;

  // defaults for the top-level parameters
  localparam int MAX_BLOCKS_DEF  = 64;
  localparam int COUNT_WIDTH_DEF = 32;

  // fixed port widths
  localparam int FUNC_W     = 2;
  localparam int BLOCK_W    = 6;
  localparam int STATUS_W   = 3;
  localparam int OUT_W      = 32;
  localparam int MASK_W     = 64;
  localparam int BIU_W      = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 64;

  // register reset values
  localparam logic [MASK_W-1:0] RADIUS_MASK_RST   = '1;
  localparam logic [BIU_W-1:0]  BLOCKS_IN_USE_RST = 7'd64;

  // function codes; the unused code behaves as a read
  localparam logic [FUNC_W-1:0] FUNC_ADD   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] STAT_COUNTED = 3'd0;
  localparam logic [STATUS_W-1:0] STAT_SKIPPED = 3'd1;
  localparam logic [STATUS_W-1:0] STAT_BAD_IDX = 3'd2;
  localparam logic [STATUS_W-1:0] STAT_READ    = 3'd3;
  localparam logic [STATUS_W-1:0] STAT_CLEARED = 3'd4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_MASK   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCKS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_UNDIRECTED    = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CLEAR
  } state_t;

endpackage

>>> src/block_edge_count_accumulator.sv
// top level of the block edge count accumulator
// depends on beca_pkg and beca_ram
//
// usage:
//   input channel (in_valid/in_ready) carries func, src_block, dst_block;
//   output channel (out_valid/out_ready) returns one result per item:
//   status, pair_count, out_degree, in_degree, total_degree.
//   config channel (cfg_valid/cfg_ready) writes radius_mask, blocks_in_use
//   and undirected_mode by index; it is always ready.
// timing:
//   the ram read is issued as the item is taken; the exec state then
//   modifies the counts, writes them back and loads the output register
//   once that register is free. one item is in flight at a time, so no
//   new item is taken until the last one has finished.
//   a clear item returns its result at once, then walks the count matrix
//   one entry a cycle (MAX_BLOCKS*MAX_BLOCKS entries, 4096 by default)
//   while no item is taken.
// reset:
//   registers return to their reset values and the same clearing pass runs.
// stall:
//   a new item is taken while a result waits; if the output register is
//   still full when that item is ready to finish, it holds until taken.

module block_edge_count_accumulator import beca_pkg::*; #(
  parameter int MAX_BLOCKS  = MAX_BLOCKS_DEF,
  parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [FUNC_W-1:0]     func,
  input  logic [BLOCK_W-1:0]    src_block,
  input  logic [BLOCK_W-1:0]    dst_block,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [STATUS_W-1:0]   status,
  output logic [OUT_W-1:0]      pair_count,
  output logic [OUT_W-1:0]      out_degree,
  output logic [OUT_W-1:0]      in_degree,
  output logic [OUT_W-1:0]      total_degree,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int BLK_W  = $clog2(MAX_BLOCKS);
  localparam int CELLS  = MAX_BLOCKS * MAX_BLOCKS;
  localparam int CELL_W = $clog2(CELLS);
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  state_t state, state_next;

  // configuration registers
  logic [MASK_W-1:0] radius_mask;
  logic [BIU_W-1:0]  blocks_in_use;
  logic              undirected_mode;

  // item held while it is worked on
  logic [FUNC_W-1:0]  func_q;
  logic [BLOCK_W-1:0] src_q;
  logic [BLOCK_W-1:0] dst_q;

  logic [CELL_W-1:0] sweep_addr;
  logic              sweep_last;

  logic [BLOCK_W-1:0] rd_src, rd_dst;
  logic [BLK_W-1:0]   src_idx, dst_idx;
  logic [CELL_W-1:0]  cell_addr;

  logic [COUNT_WIDTH-1:0] cnt_rd, outd_rd, ind_dst_rd, ind_src_rd;
  logic [COUNT_WIDTH-1:0] cnt_new, outd_new, ind_dst_new, ind_src_new, total_new;
  logic [COUNT_WIDTH:0]   total_sum;

  logic is_add, is_clear, src_ok, dst_ok, idx_ok, in_radius, counted;
  logic exec_done, clearing;

  logic                   cnt_we, deg_we;
  logic [CELL_W-1:0]      cnt_waddr;
  logic [BLK_W-1:0]       deg_waddr_o, deg_waddr_i;
  logic [COUNT_WIDTH-1:0] cnt_wdata, outd_wdata, ind_wdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius_mask     <= RADIUS_MASK_RST;
      blocks_in_use   <= BLOCKS_IN_USE_RST;
      undirected_mode <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_RADIUS_MASK:   radius_mask     <= cfg_data;
        REG_BLOCKS_IN_USE: blocks_in_use   <= cfg_data[BIU_W-1:0];
        REG_UNDIRECTED:    undirected_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // ram read address comes straight from the ports while idle
  assign rd_src    = (state == ST_IDLE) ? src_block : src_q;
  assign rd_dst    = (state == ST_IDLE) ? dst_block : dst_q;
  assign src_idx   = BLK_W'(rd_src);
  assign dst_idx   = BLK_W'(rd_dst);
  assign cell_addr = CELL_W'(src_idx) * CELL_W'(MAX_BLOCKS) + CELL_W'(dst_idx);

  // index checks against the block count and the store size
  assign is_add    = (func_q == FUNC_ADD);
  assign is_clear  = (func_q == FUNC_CLEAR);
  assign src_ok    = ({1'b0, src_q} < blocks_in_use) && (32'(src_q) < 32'(MAX_BLOCKS));
  assign dst_ok    = ({1'b0, dst_q} < blocks_in_use) && (32'(dst_q) < 32'(MAX_BLOCKS));
  assign idx_ok    = src_ok && dst_ok;
  assign in_radius = radius_mask[src_q] && radius_mask[dst_q];
  assign counted   = is_add && idx_ok && in_radius;

  // saturating increments
  always_comb begin
    cnt_new     = cnt_rd;
    outd_new    = outd_rd;
    ind_dst_new = ind_dst_rd;
    if (counted) begin
      cnt_new     = (cnt_rd == CNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
      outd_new    = (outd_rd == CNT_MAX) ? outd_rd : outd_rd + 1'b1;
      ind_dst_new = (ind_dst_rd == CNT_MAX) ? ind_dst_rd : ind_dst_rd + 1'b1;
    end
  end

  // a self edge also bumps the in-degree seen by the total
  assign ind_src_new = (counted && (src_q == dst_q)) ? ind_dst_new : ind_src_rd;
  assign total_sum   = {1'b0, outd_new} + {1'b0, ind_src_new};
  assign total_new   = undirected_mode ? outd_new :
                       (total_sum[COUNT_WIDTH] ? CNT_MAX : total_sum[COUNT_WIDTH-1:0]);

  assign exec_done  = (state == ST_EXEC) && (!out_valid || out_ready);
  assign sweep_last = (sweep_addr == CELL_W'(CELLS - 1));

  // write-back, or zeroes during the clearing pass
  always_comb begin
    cnt_we      = exec_done && counted;
    deg_we      = exec_done && counted;
    cnt_waddr   = cell_addr;
    deg_waddr_o = src_idx;
    deg_waddr_i = dst_idx;
    cnt_wdata   = cnt_new;
    outd_wdata  = outd_new;
    ind_wdata   = ind_dst_new;
    if (clearing) begin
      cnt_we      = 1'b1;
      deg_we      = (sweep_addr < CELL_W'(MAX_BLOCKS));
      cnt_waddr   = sweep_addr;
      deg_waddr_o = BLK_W'(sweep_addr);
      deg_waddr_i = BLK_W'(sweep_addr);
      cnt_wdata   = '0;
      outd_wdata  = '0;
      ind_wdata   = '0;
    end
  end

  beca_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(CELLS)) u_count_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cell_addr),
    .rdata (cnt_rd)
  );

  beca_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_BLOCKS)) u_out_deg_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr_o),
    .wdata (outd_wdata),
    .raddr (src_idx),
    .rdata (outd_rd)
  );

  // two copies of the in-degrees: one read at the column, one at the row
  beca_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_BLOCKS)) u_in_deg_dst_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr_i),
    .wdata (ind_wdata),
    .raddr (dst_idx),
    .rdata (ind_dst_rd)
  );

  beca_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(MAX_BLOCKS)) u_in_deg_src_ram (
    .clk   (clk),
    .we    (deg_we),
    .waddr (deg_waddr_i),
    .wdata (ind_wdata),
    .raddr (src_idx),
    .rdata (ind_src_rd)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (exec_done) begin
          state_next = is_clear ? ST_CLEAR : ST_IDLE;
        end
      end
      ST_CLEAR: begin
        if (sweep_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready = 1'b0;
    clearing = 1'b0;
    case (state)
      ST_IDLE:  in_ready = 1'b1;
      ST_EXEC:  ;
      ST_CLEAR: clearing = 1'b1;
      default:  ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      sweep_addr <= '0;
    end else begin
      state <= state_next;
      if (exec_done) begin
        sweep_addr <= '0;
      end else if (clearing) begin
        sweep_addr <= sweep_addr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      func_q <= func;
      src_q  <= src_block;
      dst_q  <= dst_block;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_done) begin
      if (is_clear || !idx_ok) begin
        status       <= is_clear ? STAT_CLEARED : STAT_BAD_IDX;
        pair_count   <= '0;
        out_degree   <= '0;
        in_degree    <= '0;
        total_degree <= '0;
      end else begin
        if (is_add) begin
          status <= counted ? STAT_COUNTED : STAT_SKIPPED;
        end else begin
          status <= STAT_READ;
        end
        pair_count   <= OUT_W'(cnt_new);
        out_degree   <= OUT_W'(outd_new);
        in_degree    <= OUT_W'(ind_dst_new);
        total_degree <= OUT_W'(total_new);
      end
    end
  end

endmodule

>>> src/beca_ram.sv
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module beca_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> verif/block_edge_count_accumulator_test.sv
// self-checking testbench for block_edge_count_accumulator
// depends on beca_pkg and the accumulator rtl; edge items are checked against a
// predictor of the count matrix and degree tables under several register settings
`timescale 1ns / 100ps

module block_edge_count_accumulator_test;
  import beca_pkg::*;

  localparam int                NBLK           = MAX_BLOCKS_DEF;
  localparam int                WATCHDOG_LIMIT = 20000;
  localparam int                HOLD_CYCLES    = 200;
  localparam logic [FUNC_W-1:0] FUNC_UNDEF     = 2'd3;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [OUT_W-1:0]    pair;
    logic [OUT_W-1:0]    outd;
    logic [OUT_W-1:0]    ind;
    logic [OUT_W-1:0]    total;
  } tally_t;

  typedef struct {
    logic [FUNC_W-1:0]  fn;
    logic [BLOCK_W-1:0] src;
    logic [BLOCK_W-1:0] dst;
    bit                 fixed;
    tally_t             want;
  } dir_row_t;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  logic [FUNC_W-1:0]     func         = FUNC_READ;
  logic [BLOCK_W-1:0]    src_block    = '0;
  logic [BLOCK_W-1:0]    dst_block    = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [OUT_W-1:0]      pair_count;
  logic [OUT_W-1:0]      out_degree;
  logic [OUT_W-1:0]      in_degree;
  logic [OUT_W-1:0]      total_degree;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index    = REG_RADIUS_MASK;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // predictor state
  logic [MASK_W-1:0] radius_bits  = RADIUS_MASK_RST;
  logic [BIU_W-1:0]  live_blocks  = BLOCKS_IN_USE_RST;
  logic              undirected   = 1'b0;
  logic [OUT_W-1:0]  edge_tab [NBLK][NBLK];
  logic [OUT_W-1:0]  out_tab [NBLK];
  logic [OUT_W-1:0]  in_tab [NBLK];

  tally_t awaited_tallies [$];
  int     errors       = 0;
  int     quiet_cycles = 0;
  bit     steady       = 1'b0;
  bit     hold_req     = 1'b0;

  // mask for directed rows: blocks 5, 40 and 47 lie outside the radius
  localparam logic [MASK_W-1:0] DIR_MASK = ~((64'd1 << 5) | (64'd1 << 40) | (64'd1 << 47));

  dir_row_t directed_rows [21] = '{
    '{FUNC_READ,  6'd0,  6'd0,  1'b1, '{STAT_READ, 0, 0, 0, 0}},
    '{FUNC_READ,  6'd47, 6'd47, 1'b1, '{STAT_READ, 0, 0, 0, 0}},
    '{FUNC_ADD,   6'd0,  6'd0,  1'b1, '{STAT_COUNTED, 1, 1, 1, 2}},
    '{FUNC_ADD,   6'd47, 6'd0,  1'b1, '{STAT_SKIPPED, 0, 0, 1, 0}},
    '{FUNC_ADD,   6'd48, 6'd0,  1'b1, '{STAT_BAD_IDX, 0, 0, 0, 0}},
    '{FUNC_READ,  6'd0,  6'd48, 1'b1, '{STAT_BAD_IDX, 0, 0, 0, 0}},
    '{FUNC_ADD,   6'd63, 6'd63, 1'b1, '{STAT_BAD_IDX, 0, 0, 0, 0}},
    '{FUNC_UNDEF, 6'd0,  6'd0,  1'b1, '{STAT_READ, 1, 1, 1, 2}},
    '{FUNC_ADD,   6'd0,  6'd5,  1'b0, '0},
    '{FUNC_ADD,   6'd40, 6'd46, 1'b0, '0},
    '{FUNC_ADD,   6'd46, 6'd0,  1'b0, '0},
    '{FUNC_ADD,   6'd0,  6'd46, 1'b0, '0},
    '{FUNC_ADD,   6'd0,  6'd46, 1'b0, '0},
    '{FUNC_READ,  6'd46, 6'd46, 1'b0, '0},
    '{FUNC_ADD,   6'd42, 6'd21, 1'b0, '0},
    '{FUNC_ADD,   6'd21, 6'd42, 1'b0, '0},
    '{FUNC_CLEAR, 6'd63, 6'd63, 1'b1, '{STAT_CLEARED, 0, 0, 0, 0}},
    '{FUNC_READ,  6'd0,  6'd46, 1'b1, '{STAT_READ, 0, 0, 0, 0}},
    '{FUNC_CLEAR, 6'd0,  6'd0,  1'b1, '{STAT_CLEARED, 0, 0, 0, 0}},
    '{FUNC_ADD,   6'd46, 6'd46, 1'b0, '0},
    '{FUNC_READ,  6'd63, 6'd0,  1'b1, '{STAT_BAD_IDX, 0, 0, 0, 0}}
  };

  block_edge_count_accumulator uut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .src_block    (src_block),
    .dst_block    (dst_block),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .pair_count   (pair_count),
    .out_degree   (out_degree),
    .in_degree    (in_degree),
    .total_degree (total_degree),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic void wipe_counts();
    for (int r = 0; r < NBLK; r++) begin
      out_tab[r] = '0;
      in_tab[r]  = '0;
      for (int c = 0; c < NBLK; c++) edge_tab[r][c] = '0;
    end
  endfunction

  function automatic logic [OUT_W-1:0] sat_inc(input logic [OUT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  // applies one item to the predicted tables and returns the result it yields
  function automatic tally_t tally_item(input logic [FUNC_W-1:0] f,
                                        input logic [BLOCK_W-1:0] s,
                                        input logic [BLOCK_W-1:0] d);
    tally_t           t;
    int               lim;
    logic [OUT_W:0]   sum;
    t   = '0;
    lim = (live_blocks < NBLK) ? live_blocks : NBLK;
    if (f == FUNC_CLEAR) begin
      wipe_counts();
      t.status = STAT_CLEARED;
      return t;
    end
    if (s >= lim || d >= lim) begin
      t.status = STAT_BAD_IDX;
      return t;
    end
    if (f == FUNC_ADD) begin
      if (radius_bits[s] && radius_bits[d]) begin
        edge_tab[s][d] = sat_inc(edge_tab[s][d]);
        out_tab[s]     = sat_inc(out_tab[s]);
        in_tab[d]      = sat_inc(in_tab[d]);
        t.status       = STAT_COUNTED;
      end else begin
        t.status = STAT_SKIPPED;
      end
    end else begin
      t.status = STAT_READ;
    end
    t.pair = edge_tab[s][d];
    t.outd = out_tab[s];
    t.ind  = in_tab[d];
    sum    = {1'b0, out_tab[s]} + {1'b0, in_tab[s]};
    if (undirected) t.total = out_tab[s];
    else t.total = sum[OUT_W] ? '1 : sum[OUT_W-1:0];
    return t;
  endfunction

  // mostly back to back, some short gaps, a few long ones
  function automatic int draw_gap();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 15);
    if (r < 9) return 0;
    if (r < 14) return $urandom_range(1, 3);
    if (r < 15) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // hot low blocks build up counts; some indices anywhere to hit the bad case
  function automatic logic [BLOCK_W-1:0] draw_block(input int lim);
    if (lim == 0 || $urandom_range(0, 9) == 0) return BLOCK_W'($urandom_range(0, NBLK - 1));
    if ($urandom_range(0, 1) == 1) return BLOCK_W'($urandom_range(0, ((lim < 4) ? lim : 4) - 1));
    return BLOCK_W'($urandom_range(0, lim - 1));
  endfunction

  task automatic offer_item(input logic [FUNC_W-1:0] f, input logic [BLOCK_W-1:0] s,
                            input logic [BLOCK_W-1:0] d, input bit fixed,
                            input tally_t fixed_val);
    int     gap;
    tally_t t;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    func      <= f;
    src_block <= s;
    dst_block <= d;
    do @(posedge clk); while (!in_ready);
    t = tally_item(f, s, d);
    awaited_tallies.insert(awaited_tallies.size(), fixed ? fixed_val : t);
  endtask

  // only once every result is back and any clearing walk has finished
  task automatic load_registers(input logic [MASK_W-1:0] mask, input logic [BIU_W-1:0] nblk,
                                input logic undir);
    logic [CFG_IDX_W-1:0]  idx  [3];
    logic [CFG_DATA_W-1:0] vals [3];
    idx  = '{REG_RADIUS_MASK, REG_BLOCKS_IN_USE, REG_UNDIRECTED};
    vals = '{mask, CFG_DATA_W'(nblk), CFG_DATA_W'(undir)};
    do @(posedge clk); while (awaited_tallies.size() != 0 || !in_ready);
    for (int r = 0; r < 3; r++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[r];
      cfg_data  <= vals[r];
      do @(posedge clk); while (!cfg_ready);
      case (idx[r])
        REG_RADIUS_MASK:   radius_bits = vals[r][MASK_W-1:0];
        REG_BLOCKS_IN_USE: live_blocks = vals[r][BIU_W-1:0];
        REG_UNDIRECTED:    undirected  = vals[r][0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int hold_left;
    int stall_left;
    tally_t exp_t;
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) begin
        if (awaited_tallies.size() == 0) begin
          $error("result item with no item outstanding");
          errors++;
        end else begin
          exp_t = awaited_tallies.pop_front();
          if (status !== exp_t.status) begin
            $error("status: expected %0d, got %0d", exp_t.status, status);
            errors++;
          end
          if (pair_count !== exp_t.pair) begin
            $error("pair_count: expected %0d, got %0d", exp_t.pair, pair_count);
            errors++;
          end
          if (out_degree !== exp_t.outd) begin
            $error("out_degree: expected %0d, got %0d", exp_t.outd, out_degree);
            errors++;
          end
          if (in_degree !== exp_t.ind) begin
            $error("in_degree: expected %0d, got %0d", exp_t.ind, in_degree);
            errors++;
          end
          if (total_degree !== exp_t.total) begin
            $error("total_degree: expected %0d, got %0d", exp_t.total, total_degree);
            errors++;
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!steady && $urandom_range(0, 5) == 0) begin
        stall_left = draw_gap();
        out_ready <= (stall_left == 0);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [MASK_W-1:0]  mask;
    logic [BIU_W-1:0]   nblk;
    logic               undir;
    logic [FUNC_W-1:0]  f;
    int                 n_items;
    int                 lim;
    int                 r;
    wipe_counts();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    load_registers(DIR_MASK, 7'd48, 1'b0);
    foreach (directed_rows[i])
      offer_item(directed_rows[i].fn, directed_rows[i].src, directed_rows[i].dst,
                 directed_rows[i].fixed, directed_rows[i].want);
    in_valid <= 1'b0;

    for (int p = 0; p < 8; p++) begin
      n_items = 165;
      steady  = 1'b0;
      undir   = 1'b0;
      nblk    = 7'd64;
      mask    = {$urandom, $urandom} | {$urandom, $urandom};
      case (p)
        0: begin
          mask   = '1;
          steady = 1'b1;
        end
        1: begin
          mask  = '0;
          undir = 1'b1;
        end
        2: begin
          mask = {$urandom, $urandom};
          nblk = 7'd1;
        end
        3: begin
          nblk  = 7'd127;
          undir = 1'b1;
        end
        4: begin
          // no blocks in use: every index is bad
          nblk    = 7'd0;
          n_items = 50;
        end
        5: begin
          nblk  = BIU_W'($urandom_range(2, 63));
          undir = 1'($urandom_range(0, 1));
        end
        6: begin
          // long receiver hold-off while items keep coming
          mask   = '1;
          steady = 1'b1;
        end
        default: ;
      endcase
      load_registers(mask, nblk, undir);
      if (p == 6) hold_req = 1'b1;
      lim = (live_blocks < NBLK) ? live_blocks : NBLK;
      for (int k = 0; k < n_items; k++) begin
        r = $urandom_range(0, 99);
        if (r < 1) f = FUNC_CLEAR;
        else if (r < 3) f = FUNC_UNDEF;
        else if (r < 20) f = FUNC_READ;
        else f = FUNC_ADD;
        offer_item(f, draw_block(lim), draw_block(lim), 1'b0, '0);
      end
      in_valid <= 1'b0;
    end

    do @(posedge clk); while (awaited_tallies.size() != 0);
    repeat (20) @(posedge clk);
    if (awaited_tallies.size() != 0) begin
      $error("%0d result items never arrived", awaited_tallies.size());
      errors++;
    end
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
